>>> design/magstripe_track_encoder_defines.svh
// assertion macros shared by the magstripe track encoder modules
`ifndef MAGSTRIPE_TRACK_ENCODER_DEFINES_SVH
`define MAGSTRIPE_TRACK_ENCODER_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define MTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define MTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mte_pkg.sv
// types and constants of the magstripe track encoder
`timescale 1ns / 1ps

package mte_pkg;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_BITS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_OFFSET = 1'd1;

  localparam logic [3:0] CHAR_BITS_RESET   = 4'd7;
  localparam logic [7:0] CHAR_OFFSET_RESET = 8'd32;

  // item modes
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam int WORD_W  = 7;
  localparam int NBITS_W = 3;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic first_half;
    logic second_half;
    logic data_bit;
    logic last_of_char;
  } out_t;

  // one classified character waiting for the serializer
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [NBITS_W-1:0] nbits;
    logic               parity;
  } job_t;

endpackage

>>> design/mte_front.sv
// front end: config registers, character classification and check accumulation
`timescale 1ns / 1ps

module mte_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mte_pkg::in_t                  in_data,
  output logic                          job_push,
  output mte_pkg::job_t                 job_data,
  input  logic                          job_full
);
  import mte_pkg::*;

  logic [3:0]         char_bits;
  logic [7:0]         char_offset;
  logic [WORD_W-1:0]  check_accum;
  logic [NBITS_W-1:0] nbits;
  logic [7:0]         diff;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  word_masked;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_bits   <= CHAR_BITS_RESET;
      char_offset <= CHAR_OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHAR_BITS:   char_bits   <= cfg_data[3:0];
        REG_CHAR_OFFSET: char_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // data bits per character: char_bits clamped to 1..8, minus parity
  always_comb begin
    if (char_bits > 4'd8) begin
      nbits = NBITS_W'(7);
    end else if (char_bits == 4'd0) begin
      nbits = '0;
    end else begin
      nbits = NBITS_W'(char_bits - 4'd1);
    end
  end

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      mask[i] = (NBITS_W'(i) < nbits);
    end
  end

  assign diff        = in_data.char_code - char_offset;
  assign word        = (in_data.mode == MODE_END) ? check_accum : diff[WORD_W-1:0];
  assign word_masked = word & mask;

  assign in_stall = job_full;
  assign job_push = in_valid && !job_full;

  assign job_data.word   = word_masked;
  assign job_data.nbits  = nbits;
  assign job_data.parity = ~(^word_masked);

  always_ff @(posedge clk) begin
    if (rst) begin
      check_accum <= '0;
    end else if (job_push) begin
      check_accum <= (in_data.mode == MODE_END) ? '0 : (check_accum ^ word_masked);
    end
  end

endmodule

>>> design/mte_queue.sv
// short queue of classified characters between front and back
`timescale 1ns / 1ps
`include "magstripe_track_encoder_defines.svh"

module mte_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mte_pkg::job_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output mte_pkg::job_t rd_data
);
  import mte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `MTE_ASSERT_NOW(a_no_overflow, full, !push, "push into a full queue")
  `MTE_ASSERT_NOW(a_no_underflow, pop, rd_valid, "pop from an empty queue")
  `MTE_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(DEPTH), "queue count out of range")

endmodule

>>> design/mte_back.sv
// back end: bit-cell serializer with f2f flux tracking and output register
`timescale 1ns / 1ps
`include "magstripe_track_encoder_defines.svh"

module mte_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  mte_pkg::job_t job_data,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output mte_pkg::out_t out_data
);
  import mte_pkg::*;

  logic [NBITS_W-1:0] pos;
  logic               flux_level;
  logic               fire;
  logic               last;
  logic               cell_bit;
  logic [7:0]         word_ext;
  logic               first_lvl;
  logic               second_lvl;

  assign fire     = job_valid && (!out_valid || !out_stall);
  assign last     = (pos == job_data.nbits);
  assign word_ext = {1'b0, job_data.word};
  assign cell_bit = last ? job_data.parity : word_ext[pos];
  assign job_pop  = fire && last;

  // level flips at cell start, and again mid-cell for a one
  assign first_lvl  = ~flux_level;
  assign second_lvl = first_lvl ^ cell_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      flux_level <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        pos        <= last ? '0 : pos + NBITS_W'(1);
        flux_level <= second_lvl;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.first_half   <= first_lvl;
      out_data.second_half  <= second_lvl;
      out_data.data_bit     <= cell_bit;
      out_data.last_of_char <= last;
    end
  end

  `MTE_ASSERT_NOW(a_f2f_cell, out_valid,
    out_data.second_half == (out_data.first_half ^ out_data.data_bit),
    "cell halves disagree with data bit")
  `MTE_ASSERT_NEXT(a_pos_step, fire && !last, pos == $past(pos) + NBITS_W'(1),
    "bit position did not advance")
  `MTE_ASSERT_NEXT(a_flux_track, fire, flux_level == out_data.second_half,
    "flux level lost track of the last cell")

endmodule

>>> design/magstripe_track_encoder.sv
// Magnetic stripe track encoder with F2F (biphase-mark) cell output. Each
// accepted item produces one bit cell per result transfer: the data bits of
// the character (code minus char_offset, or the longitudinal check register
// for an end-of-track item), least significant first, then an odd parity cell
// flagged by last_of_char. An item gives char_bits cells (clamped to 1..8),
// one cell per cycle unless out_stall holds the single-cell serializer. A new
// item is taken while the previous one is still being serialized; the queue
// between classifier and serializer holds QUEUE_DEPTH items. Configuration is
// written via cfg_we/cfg_index/cfg_data by the user only while idle; unchecked.
`timescale 1ns / 1ps

module magstripe_track_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mte_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mte_pkg::out_t                  out_data
);
  import mte_pkg::*;

  logic job_push;
  job_t job_wr;
  logic job_full;
  logic job_pop;
  logic job_valid;
  job_t job_rd;

  mte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_push  (job_push),
    .job_data  (job_wr),
    .job_full  (job_full)
  );

  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .wr_data  (job_wr),
    .full     (job_full),
    .pop      (job_pop),
    .rd_valid (job_valid),
    .rd_data  (job_rd)
  );

  mte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_data  (job_rd),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
